### hdl/bpc_pkg.sv
// Shared types, field offsets and codes of the bitmask pixel collision unit.
`timescale 1ns / 1ps
`default_nettype none

package bpc_pkg;

   // Mask side length that the design is built for by default, and the largest it supports.
   localparam int MAX_DIM_DEFAULT = 64;
   localparam int MAX_DIM_HIGH    = 256;

   // Row, column and count fields between front and back, sized for the largest mask.
   localparam int POS_W = $clog2(MAX_DIM_HIGH + 1);

   // Request channel layout.
   localparam int COORD_W         = 16;
   localparam int REQ_TDATA_W     = 136;
   localparam int REQ_TUSER_W     = 4;
   localparam int START_X_LSB     = 0;
   localparam int START_Y_LSB     = 16;
   localparam int END_X_LSB       = 32;
   localparam int END_Y_LSB       = 48;
   localparam int PIXEL_VALUE_BIT = 64;
   localparam int POS_A_X_LSB     = 65;
   localparam int POS_A_Y_LSB     = 81;
   localparam int POS_B_X_LSB     = 97;
   localparam int POS_B_Y_LSB     = 113;
   localparam int COMMAND_LSB     = 0;
   localparam int COMMAND_W       = 2;
   localparam int WHICH_MASK_BIT  = 2;
   localparam int BOX_ONLY_BIT    = 3;

   // Result channel layout.
   localparam int RSP_TDATA_W = 8;
   localparam int HIT_BIT     = 0;
   localparam int OVERLAP_BIT = 1;

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 7;
   localparam logic [CSR_DATA_W-1:0] CSR_SIZE_RESET = CSR_DATA_W'(64);

   // Entries in the queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [COMMAND_W-1:0] {
      CMD_WRITE = 2'd0,
      CMD_FILL  = 2'd1,
      CMD_TEST  = 2'd2
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WIDTH_A  = 2'd0,
      CSR_HEIGHT_A = 2'd1,
      CSR_WIDTH_B  = 2'd2,
      CSR_HEIGHT_B = 2'd3
   } csr_index_type;

   // What the back end does with a queued operation.
   typedef enum logic [1:0] {
      KIND_RESULT,   // nothing to do, the result bits travel with the entry
      KIND_FILL,     // write a run of columns into a run of rows
      KIND_SCAN      // AND rows of both masks over the overlap rectangle
   } kind_type;

   typedef struct packed {
      kind_type         kind;
      logic             sel;
      logic             val;
      logic             res_hit;
      logic             res_overlap;
      logic [POS_W-1:0] row_a;
      logic [POS_W-1:0] row_b;
      logic [POS_W-1:0] rows;
      logic [POS_W-1:0] col_a;
      logic [POS_W-1:0] col_b;
      logic [POS_W-1:0] cols;
   } op_type;

endpackage

`default_nettype wire

### hdl/bpc_front.sv
// Front end: size registers, command decode, clipping and box rejection.
`timescale 1ns / 1ps
`default_nettype none

module bpc_front #(
   parameter int MAX_DIM = bpc_pkg::MAX_DIM_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [bpc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [bpc_pkg::CSR_DATA_W-1:0]   csr_data,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [bpc_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  wire logic [bpc_pkg::REQ_TUSER_W-1:0]  req_tuser,
   output logic                                  push_valid,
   input  wire logic                             push_ready,
   output bpc_pkg::op_type                       push_data
);

   // Coordinates plus a mask size cannot leave this range.
   localparam int CW = bpc_pkg::COORD_W + 2;
   localparam logic signed [CW-1:0] DIM_S = CW'(MAX_DIM);

   typedef struct packed {
      bpc_pkg::cmd_type      cmd;
      logic                  sel;
      logic                  val;
      logic                  box;
      logic signed [CW-1:0]  xs;
      logic signed [CW-1:0]  xe;
      logic signed [CW-1:0]  ys;
      logic signed [CW-1:0]  ye;
      logic signed [CW-1:0]  ax;
      logic signed [CW-1:0]  ay;
      logic signed [CW-1:0]  bx;
      logic signed [CW-1:0]  by;
      logic signed [CW-1:0]  ar;
      logic signed [CW-1:0]  ab;
      logic signed [CW-1:0]  br;
      logic signed [CW-1:0]  bb;
   } stage_type;

   logic [bpc_pkg::CSR_DATA_W-1:0] width_a_ff, height_a_ff, width_b_ff, height_b_ff;
   logic                           stage_valid_ff;
   stage_type                      stage_ff, stage_in;

   logic signed [CW-1:0] wa, ha, wb, hb, w_sel, h_sel;
   logic signed [CW-1:0] sx, sy, ex, ey, ex_eff, ey_eff;

   function automatic logic signed [CW-1:0] eff_dim(input logic [bpc_pkg::CSR_DATA_W-1:0] v);
      logic signed [CW-1:0] raw;
      raw = CW'(v);
      return (raw > DIM_S) ? DIM_S : raw;
   endfunction

   function automatic logic signed [CW-1:0] sext(input logic [bpc_pkg::COORD_W-1:0] v);
      return CW'($signed(v));
   endfunction

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_a_ff  <= bpc_pkg::CSR_SIZE_RESET;
         height_a_ff <= bpc_pkg::CSR_SIZE_RESET;
         width_b_ff  <= bpc_pkg::CSR_SIZE_RESET;
         height_b_ff <= bpc_pkg::CSR_SIZE_RESET;
      end else if (csr_valid) begin
         case (bpc_pkg::csr_index_type'(csr_index))
            bpc_pkg::CSR_WIDTH_A:  width_a_ff  <= csr_data;
            bpc_pkg::CSR_HEIGHT_A: height_a_ff <= csr_data;
            bpc_pkg::CSR_WIDTH_B:  width_b_ff  <= csr_data;
            bpc_pkg::CSR_HEIGHT_B: height_b_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // First step: sign extension, clipping of the fill rectangle, box edges.
   always_comb begin
      wa = eff_dim(width_a_ff);
      ha = eff_dim(height_a_ff);
      wb = eff_dim(width_b_ff);
      hb = eff_dim(height_b_ff);

      stage_in.cmd = bpc_pkg::cmd_type'(req_tuser[bpc_pkg::COMMAND_LSB +: bpc_pkg::COMMAND_W]);
      stage_in.sel = req_tuser[bpc_pkg::WHICH_MASK_BIT];
      stage_in.box = req_tuser[bpc_pkg::BOX_ONLY_BIT];
      stage_in.val = req_tdata[bpc_pkg::PIXEL_VALUE_BIT];

      sx = sext(req_tdata[bpc_pkg::START_X_LSB +: bpc_pkg::COORD_W]);
      sy = sext(req_tdata[bpc_pkg::START_Y_LSB +: bpc_pkg::COORD_W]);
      ex = sext(req_tdata[bpc_pkg::END_X_LSB +: bpc_pkg::COORD_W]);
      ey = sext(req_tdata[bpc_pkg::END_Y_LSB +: bpc_pkg::COORD_W]);

      // A single pixel write is a one by one fill.
      ex_eff = (stage_in.cmd == bpc_pkg::CMD_WRITE) ? sx + CW'(1) : ex;
      ey_eff = (stage_in.cmd == bpc_pkg::CMD_WRITE) ? sy + CW'(1) : ey;
      w_sel  = stage_in.sel ? wb : wa;
      h_sel  = stage_in.sel ? hb : ha;

      stage_in.xs = (sx < 0) ? '0 : sx;
      stage_in.ys = (sy < 0) ? '0 : sy;
      stage_in.xe = (ex_eff < w_sel) ? ex_eff : w_sel;
      stage_in.ye = (ey_eff < h_sel) ? ey_eff : h_sel;

      stage_in.ax = sext(req_tdata[bpc_pkg::POS_A_X_LSB +: bpc_pkg::COORD_W]);
      stage_in.ay = sext(req_tdata[bpc_pkg::POS_A_Y_LSB +: bpc_pkg::COORD_W]);
      stage_in.bx = sext(req_tdata[bpc_pkg::POS_B_X_LSB +: bpc_pkg::COORD_W]);
      stage_in.by = sext(req_tdata[bpc_pkg::POS_B_Y_LSB +: bpc_pkg::COORD_W]);
      stage_in.ar = stage_in.ax + wa;
      stage_in.ab = stage_in.ay + ha;
      stage_in.br = stage_in.bx + wb;
      stage_in.bb = stage_in.by + hb;
   end

   assign req_tready = !stage_valid_ff || push_ready;
   assign push_valid = stage_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_tready) begin
         stage_valid_ff <= req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         stage_ff <= stage_in;
      end
   end

   // Second step: classify the command and hand the back end row and column ranges.
   logic signed [CW-1:0] ol, ot, orr, obt;
   logic signed [CW-1:0] fill_rows, fill_cols, ov_rows, ov_cols;
   logic signed [CW-1:0] row_a, row_b, col_a, col_b;
   logic                 reject;

   always_comb begin
      ol  = ($signed(stage_ff.ax) > $signed(stage_ff.bx)) ? stage_ff.ax : stage_ff.bx;
      ot  = ($signed(stage_ff.ay) > $signed(stage_ff.by)) ? stage_ff.ay : stage_ff.by;
      orr = ($signed(stage_ff.ar) < $signed(stage_ff.br)) ? stage_ff.ar : stage_ff.br;
      obt = ($signed(stage_ff.ab) < $signed(stage_ff.bb)) ? stage_ff.ab : stage_ff.bb;

      fill_rows = stage_ff.ye - stage_ff.ys;
      fill_cols = stage_ff.xe - stage_ff.xs;
      ov_rows   = obt - ot;
      ov_cols   = orr - ol;
      row_a     = ot - stage_ff.ay;
      row_b     = ot - stage_ff.by;
      col_a     = ol - stage_ff.ax;
      col_b     = ol - stage_ff.bx;

      // Boxes that only touch along an edge are not rejected.
      reject = ($signed(stage_ff.ab) < $signed(stage_ff.by))
            || ($signed(stage_ff.ay) > $signed(stage_ff.bb))
            || ($signed(stage_ff.ar) < $signed(stage_ff.bx))
            || ($signed(stage_ff.ax) > $signed(stage_ff.br));

      push_data      = '0;
      push_data.kind = bpc_pkg::KIND_RESULT;
      push_data.sel  = stage_ff.sel;
      push_data.val  = stage_ff.val;

      case (stage_ff.cmd)
         bpc_pkg::CMD_WRITE, bpc_pkg::CMD_FILL: begin
            if (($signed(fill_rows) > 0) && ($signed(fill_cols) > 0)) begin
               push_data.kind  = bpc_pkg::KIND_FILL;
               push_data.row_a = stage_ff.ys[bpc_pkg::POS_W-1:0];
               push_data.rows  = fill_rows[bpc_pkg::POS_W-1:0];
               push_data.col_a = stage_ff.xs[bpc_pkg::POS_W-1:0];
               push_data.cols  = fill_cols[bpc_pkg::POS_W-1:0];
            end
         end
         bpc_pkg::CMD_TEST: begin
            if (!reject) begin
               push_data.res_overlap = 1'b1;
               if (stage_ff.box) begin
                  push_data.res_hit = 1'b1;
               end else if (($signed(ov_rows) > 0) && ($signed(ov_cols) > 0)) begin
                  push_data.kind  = bpc_pkg::KIND_SCAN;
                  push_data.row_a = row_a[bpc_pkg::POS_W-1:0];
                  push_data.row_b = row_b[bpc_pkg::POS_W-1:0];
                  push_data.rows  = ov_rows[bpc_pkg::POS_W-1:0];
                  push_data.col_a = col_a[bpc_pkg::POS_W-1:0];
                  push_data.col_b = col_b[bpc_pkg::POS_W-1:0];
                  push_data.cols  = ov_cols[bpc_pkg::POS_W-1:0];
               end
            end
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

### hdl/bpc_queue.sv
// Short queue of classified operations between front and back end.
`timescale 1ns / 1ps
`default_nettype none

module bpc_queue (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push_valid,
   output logic                 push_ready,
   input  wire bpc_pkg::op_type push_data,
   output logic                 pop_valid,
   input  wire logic            pop_ready,
   output bpc_pkg::op_type      pop_data
);

   localparam int DEPTH = bpc_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   bpc_pkg::op_type   entries_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         count_ff <= count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### hdl/bpc_back.sv
// Back end: the two mask memories, row-wise fill and row-wise collision scan.
`timescale 1ns / 1ps
`default_nettype none

module bpc_back #(
   parameter int MAX_DIM = bpc_pkg::MAX_DIM_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             pop_valid,
   output logic                                  pop_ready,
   input  wire bpc_pkg::op_type                  pop_data,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [bpc_pkg::RSP_TDATA_W-1:0]       rsp_tdata
);

   localparam int IDX_W = $clog2(MAX_DIM);
   localparam int CNT_W = $clog2(MAX_DIM + 1);
   localparam logic [CNT_W-1:0]   DIM_C    = CNT_W'(MAX_DIM);
   localparam logic [MAX_DIM-1:0] ALL_ONES = '1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type          state_ff;
   bpc_pkg::op_type    op_ff;
   logic [IDX_W-1:0]   row_a_ff, row_b_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [MAX_DIM-1:0] colmask_ff, colmask_in, run_mask;
   logic               hit_ff, rd_valid_ff;
   logic               rsp_valid_ff, rsp_hit_ff, rsp_ovl_ff;

   logic [MAX_DIM-1:0] mask_a_mem_ff [MAX_DIM];
   logic [MAX_DIM-1:0] mask_b_mem_ff [MAX_DIM];
   logic [MAX_DIM-1:0] rd_a_ff, rd_b_ff;

   logic out_free, take, row_hit;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign pop_ready = (state_ff == ST_IDLE)
                   && ((pop_data.kind != bpc_pkg::KIND_RESULT) || out_free);
   assign take      = pop_valid && pop_ready;

   // Columns [0, cols) as ones; a fill moves the run up to its first column.
   assign run_mask   = ALL_ONES >> (DIM_C - pop_data.cols[CNT_W-1:0]);
   assign colmask_in = (pop_data.kind == bpc_pkg::KIND_FILL)
                     ? (run_mask << pop_data.col_a[IDX_W-1:0]) : run_mask;

   // Align both rows on the overlap's left edge and look for a common set pixel.
   assign row_hit = |((rd_a_ff >> op_ff.col_a[IDX_W-1:0])
                    & (rd_b_ff >> op_ff.col_b[IDX_W-1:0]) & colmask_ff);

   always_ff @(posedge clock) begin
      if (state_ff == ST_FILL) begin
         for (int i = 0; i < MAX_DIM; i++) begin
            if (colmask_ff[i]) begin
               if (op_ff.sel) begin
                  mask_b_mem_ff[row_a_ff][i] <= op_ff.val;
               end else begin
                  mask_a_mem_ff[row_a_ff][i] <= op_ff.val;
               end
            end
         end
      end
      if (state_ff == ST_SCAN) begin
         rd_a_ff <= mask_a_mem_ff[row_a_ff];
         rd_b_ff <= mask_b_mem_ff[row_b_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         rd_valid_ff <= (state_ff == ST_SCAN);
         if (rd_valid_ff && row_hit) begin
            hit_ff <= 1'b1;
         end

         case (state_ff)
            ST_IDLE: begin
               if (take) begin
                  op_ff      <= pop_data;
                  row_a_ff   <= pop_data.row_a[IDX_W-1:0];
                  row_b_ff   <= pop_data.row_b[IDX_W-1:0];
                  cnt_ff     <= pop_data.rows[CNT_W-1:0];
                  colmask_ff <= colmask_in;
                  hit_ff     <= 1'b0;
                  case (pop_data.kind)
                     bpc_pkg::KIND_FILL: state_ff <= ST_FILL;
                     bpc_pkg::KIND_SCAN: state_ff <= ST_SCAN;
                     default: begin
                        rsp_valid_ff <= 1'b1;
                        rsp_hit_ff   <= pop_data.res_hit;
                        rsp_ovl_ff   <= pop_data.res_overlap;
                     end
                  endcase
               end
            end
            ST_FILL: begin
               row_a_ff <= row_a_ff + IDX_W'(1);
               cnt_ff   <= cnt_ff - CNT_W'(1);
               if (cnt_ff == CNT_W'(1)) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_SCAN: begin
               row_a_ff <= row_a_ff + IDX_W'(1);
               row_b_ff <= row_b_ff + IDX_W'(1);
               cnt_ff   <= cnt_ff - CNT_W'(1);
               if (cnt_ff == CNT_W'(1)) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_hit_ff   <= hit_ff;
                  rsp_ovl_ff   <= op_ff.res_overlap;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      rsp_tdata                       = '0;
      rsp_tdata[bpc_pkg::HIT_BIT]     = rsp_hit_ff;
      rsp_tdata[bpc_pkg::OVERLAP_BIT] = rsp_ovl_ff;
   end

endmodule

`default_nettype wire

### hdl/bitmask_pixel_collision_unit.sv
// Top level of the bitmask pixel collision unit.
//
//   Channel  Direction  Handshake                 Carries
//   req_     in         req_tvalid / req_tready   one command item (tdata, tuser)
//   rsp_     out        rsp_tvalid / rsp_tready   one result item per command
//   csr_     in         csr_valid / csr_ready     size register writes (index, data)
//
// A result passes the front stage, the queue and the back end. Box-only, rejected and empty
// items need no pass over the masks; a fill walks its clipped rows, and a scan walks the
// overlapping rows, at most MAX_DIM, reading one row of each mask per cycle.
// Reset is synchronous and active high; it sets all four sizes to 64 and empties the
// pipeline, but leaves the mask memories as they are. A held result lets the back end, the
// two-entry queue and the front stage take up to four more items before req_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module bitmask_pixel_collision_unit #(
   parameter int MAX_DIM = bpc_pkg::MAX_DIM_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // From bit 0: start_x[15:0], start_y[31:16], end_x[47:32], end_y[63:48],
   // pixel_value[64], pos_a_x[80:65], pos_a_y[96:81], pos_b_x[112:97],
   // pos_b_y[128:113], zero fill up to bit 135.
   input  wire logic [bpc_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // From bit 0: command[1:0], which_mask[2], box_only[3].
   input  wire logic [bpc_pkg::REQ_TUSER_W-1:0]  req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // From bit 0: hit[0], boxes_overlap[1], zero fill up to bit 7.
   output logic [bpc_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [bpc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [bpc_pkg::CSR_DATA_W-1:0]   csr_data
);

   // Classified operations flow from the front end through the queue to the back end.
   logic            push_valid, push_ready;
   bpc_pkg::op_type push_data;
   logic            pop_valid, pop_ready;
   bpc_pkg::op_type pop_data;

   // The front end holds the size registers, clips fill rectangles and decides the
   // bounding box test, so the back end only ever walks rows.
   bpc_front #(
      .MAX_DIM (MAX_DIM)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // The queue lets the front keep accepting while the back end runs a long scan.
   bpc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Operations run strictly in order, so every fill lands before a later test reads.
   bpc_back #(
      .MAX_DIM (MAX_DIM)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

### hdl/bpc_checker.sv
// Port-level checks of the collision unit and their attachment to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bpc_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_tvalid,
   input wire logic                          req_tready,
   input wire logic                          rsp_tvalid,
   input wire logic                          rsp_tready,
   input wire logic [bpc_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   // Front stage, queue entries, the operation in the back end and the output register.
   localparam int CAPACITY = bpc_pkg::QUEUE_DEPTH + 3;

   logic [3:0] outstanding_ff;
   logic       req_take, rsp_take;

   assign req_take = req_tvalid && req_tready;
   assign rsp_take = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_ff + 4'(req_take) - 4'(rsp_take);
      end
   end

   a_idle_after_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or vanished");

   a_hit_needs_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[bpc_pkg::HIT_BIT] || rsp_tdata[bpc_pkg::OVERLAP_BIT])
      else $error("hit reported without box overlap");

   a_no_invented_result: assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> outstanding_ff != 4'd0)
      else $error("result delivered with no item outstanding");

   a_capacity: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff <= 4'(CAPACITY))
      else $error("more items in flight than the pipeline can hold");

endmodule

bind bitmask_pixel_collision_unit bpc_checker u_checker (.*);

`default_nettype wire

### test/tb.sv
// Self-checking testbench of the bitmask pixel collision unit.
`timescale 1ns / 1ps

module tb;

   // Command code 3 is not an operation; the unit must answer it with both result bits clear.
   localparam logic [bpc_pkg::COMMAND_W-1:0] CMD_UNKNOWN = 2'd3;

   // The receiver holds off once, for this many cycles, after this many result items.
   localparam int HOLD_AT     = 200;
   localparam int HOLD_CYCLES = 300;

   // The limit lies far above the slowest correct item, a full 64-row scan, above the sender's
   // longest gap and above the receiver's longest stall, the hold-off above, so that long a
   // stretch without any accepted item can only mean the unit has hung.
   localparam int WATCHDOG_LIMIT = 4000;

   // Cycles to wait after the last expected result, a little more than one full scan.
   localparam int TAIL_CYCLES = 80;

   // One command item with every field at its own width.
   typedef struct {
      logic [bpc_pkg::COMMAND_W-1:0] command;
      logic                          which_mask;
      logic signed [15:0]            start_x;
      logic signed [15:0]            start_y;
      logic signed [15:0]            end_x;
      logic signed [15:0]            end_y;
      logic                          pixel_value;
      logic signed [15:0]            pos_a_x;
      logic signed [15:0]            pos_a_y;
      logic signed [15:0]            pos_b_x;
      logic signed [15:0]            pos_b_y;
      logic                          box_only;
   } collision_cmd_type;

   // The verdict that one command should produce, tagged with its position in the stream.
   typedef struct {
      bit hit;
      bit overlap;
      int seq;
   } collision_verdict_type;

   // Keeps its own copy of both masks and of the four size registers, works out the verdict
   // of every accepted command, and checks the result items against those verdicts in order.
   class mask_collision_checker;
      localparam int SIDE = bpc_pkg::MAX_DIM_DEFAULT;

      bit [SIDE-1:0]         rows_a [SIDE];
      bit [SIDE-1:0]         rows_b [SIDE];
      int unsigned           size_reg [4];
      collision_verdict_type pending_verdicts [$];
      int                    accepted;
      int                    mismatches;

      function new();
         size_reg = '{64, 64, 64, 64};
         accepted = 0;
         mismatches = 0;
      endfunction

      function void set_size(bpc_pkg::csr_index_type idx,
                             logic [bpc_pkg::CSR_DATA_W-1:0] value);
         size_reg[idx] = value;
      endfunction

      function int pending();
         return pending_verdicts.size();
      endfunction

      // Register values above the mask side saturate.
      function int clip_dim(int unsigned v);
         return (v > SIDE) ? SIDE : int'(v);
      endfunction

      // Fill [x0, x1) x [y0, y1) of one mask, clipped to that mask's size.
      function void paint(bit sel, int x0, int y0, int x1, int y1, bit v);
         int w, h, xs, ys, xe, ye;
         w  = clip_dim(sel ? size_reg[bpc_pkg::CSR_WIDTH_B] : size_reg[bpc_pkg::CSR_WIDTH_A]);
         h  = clip_dim(sel ? size_reg[bpc_pkg::CSR_HEIGHT_B]
                           : size_reg[bpc_pkg::CSR_HEIGHT_A]);
         xs = (x0 > 0) ? x0 : 0;
         ys = (y0 > 0) ? y0 : 0;
         xe = (x1 < w) ? x1 : w;
         ye = (y1 < h) ? y1 : h;
         for (int y = ys; y < ye; y++)
            for (int x = xs; x < xe; x++)
               if (sel) rows_b[y][x] = v;
               else rows_a[y][x] = v;
      endfunction

      function collision_verdict_type predict_verdict(collision_cmd_type cmd);
         collision_verdict_type v;
         int ax, ay, bx, by, wa, ha, wb, hb;
         int a_right, a_bottom, b_right, b_bottom;
         int left, top, right, bottom;
         v = '{hit: 1'b0, overlap: 1'b0, seq: accepted};
         case (cmd.command)
            bpc_pkg::CMD_WRITE: begin
               paint(cmd.which_mask, cmd.start_x, cmd.start_y,
                     int'(cmd.start_x) + 1, int'(cmd.start_y) + 1, cmd.pixel_value);
            end
            bpc_pkg::CMD_FILL: begin
               paint(cmd.which_mask, cmd.start_x, cmd.start_y, cmd.end_x, cmd.end_y,
                     cmd.pixel_value);
            end
            bpc_pkg::CMD_TEST: begin
               ax = cmd.pos_a_x;
               ay = cmd.pos_a_y;
               bx = cmd.pos_b_x;
               by = cmd.pos_b_y;
               wa = clip_dim(size_reg[bpc_pkg::CSR_WIDTH_A]);
               ha = clip_dim(size_reg[bpc_pkg::CSR_HEIGHT_A]);
               wb = clip_dim(size_reg[bpc_pkg::CSR_WIDTH_B]);
               hb = clip_dim(size_reg[bpc_pkg::CSR_HEIGHT_B]);
               a_right  = ax + wa;
               a_bottom = ay + ha;
               b_right  = bx + wb;
               b_bottom = by + hb;
               // Boxes whose edges only touch are not rejected.
               if (!(a_bottom < by || ay > b_bottom || a_right < bx || ax > b_right)) begin
                  v.overlap = 1'b1;
                  if (cmd.box_only) begin
                     v.hit = 1'b1;
                  end else begin
                     left   = (ax > bx) ? ax : bx;
                     top    = (ay > by) ? ay : by;
                     right  = (a_right < b_right) ? a_right : b_right;
                     bottom = (a_bottom < b_bottom) ? a_bottom : b_bottom;
                     for (int y = top; y < bottom && !v.hit; y++)
                        for (int x = left; x < right && !v.hit; x++)
                           if (rows_a[y - ay][x - ax] && rows_b[y - by][x - bx])
                              v.hit = 1'b1;
                  end
               end
            end
            default: ;
         endcase
         return v;
      endfunction

      function void accept_command(collision_cmd_type cmd);
         pending_verdicts.push_back(predict_verdict(cmd));
         accepted++;
      endfunction

      task flag_mismatch(string what);
         mismatches++;
         $display("tb: mismatch %0d at %0t ns: %s", mismatches, $time, what);
      endtask

      task check_verdict(logic [bpc_pkg::RSP_TDATA_W-1:0] data);
         collision_verdict_type want;
         if (pending_verdicts.size() == 0) begin
            flag_mismatch($sformatf("result item %b with no command waiting", data));
         end else begin
            want = pending_verdicts.pop_front();
            if (data[bpc_pkg::HIT_BIT] !== want.hit)
               flag_mismatch($sformatf("command %0d: hit %b, expected %b",
                                       want.seq, data[bpc_pkg::HIT_BIT], want.hit));
            if (data[bpc_pkg::OVERLAP_BIT] !== want.overlap)
               flag_mismatch($sformatf("command %0d: boxes_overlap %b, expected %b",
                                       want.seq, data[bpc_pkg::OVERLAP_BIT], want.overlap));
         end
      endtask
   endclass

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_tvalid = 1'b0;
   logic                                 req_tready;
   logic [bpc_pkg::REQ_TDATA_W-1:0]      req_tdata = '0;
   logic [bpc_pkg::REQ_TUSER_W-1:0]      req_tuser = '0;
   logic                                 rsp_tvalid;
   logic                                 rsp_tready = 1'b0;
   logic [bpc_pkg::RSP_TDATA_W-1:0]      rsp_tdata;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [bpc_pkg::CSR_INDEX_W-1:0]      csr_index = '0;
   logic [bpc_pkg::CSR_DATA_W-1:0]       csr_data = '0;

   // While set, the sender offers items back to back.
   bit send_burst = 1'b0;

   mask_collision_checker collision_check = new();

   always #4 clock = ~clock;

   bitmask_pixel_collision_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Idle length for either side: mostly none or a few cycles, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // A coordinate mostly in [lo, hi], sometimes anywhere in the 16-bit range.
   function automatic logic signed [15:0] near_coord(int lo, int hi);
      int v;
      if ($urandom_range(0, 99) < 8) return 16'($urandom);
      v = lo + int'($urandom_range(0, hi - lo));
      return 16'(v);
   endfunction

   // Every field random; callers overwrite the ones their command uses, so the unused
   // fields still toggle every bit.
   function automatic collision_cmd_type noise_command();
      collision_cmd_type cmd;
      cmd.command     = 2'($urandom);
      cmd.which_mask  = 1'($urandom);
      cmd.start_x     = 16'($urandom);
      cmd.start_y     = 16'($urandom);
      cmd.end_x       = 16'($urandom);
      cmd.end_y       = 16'($urandom);
      cmd.pixel_value = 1'($urandom);
      cmd.pos_a_x     = 16'($urandom);
      cmd.pos_a_y     = 16'($urandom);
      cmd.pos_b_x     = 16'($urandom);
      cmd.pos_b_y     = 16'($urandom);
      cmd.box_only    = 1'($urandom);
      return cmd;
   endfunction

   function automatic collision_cmd_type pixel_command(bit which, int x, int y, bit value);
      collision_cmd_type cmd;
      cmd = noise_command();
      cmd.command     = bpc_pkg::CMD_WRITE;
      cmd.which_mask  = which;
      cmd.start_x     = 16'(x);
      cmd.start_y     = 16'(y);
      cmd.pixel_value = value;
      return cmd;
   endfunction

   function automatic collision_cmd_type rect_command(bit which, int x0, int y0, int x1,
                                                      int y1, bit value);
      collision_cmd_type cmd;
      cmd = noise_command();
      cmd.command     = bpc_pkg::CMD_FILL;
      cmd.which_mask  = which;
      cmd.start_x     = 16'(x0);
      cmd.start_y     = 16'(y0);
      cmd.end_x       = 16'(x1);
      cmd.end_y       = 16'(y1);
      cmd.pixel_value = value;
      return cmd;
   endfunction

   function automatic collision_cmd_type test_command(int ax, int ay, int bx, int by, bit box);
      collision_cmd_type cmd;
      cmd = noise_command();
      cmd.command  = bpc_pkg::CMD_TEST;
      cmd.pos_a_x  = 16'(ax);
      cmd.pos_a_y  = 16'(ay);
      cmd.pos_b_x  = 16'(bx);
      cmd.pos_b_y  = 16'(by);
      cmd.box_only = box;
      return cmd;
   endfunction

   // A random command scaled to the current mask sizes. The span is the largest side plus a
   // margin, so writes and fills straddle the mask edges and tests mostly land near each other.
   function automatic collision_cmd_type random_command(int span, int density);
      collision_cmd_type cmd;
      int pick, off;
      cmd = noise_command();
      cmd.pixel_value = ($urandom_range(0, 99) < density);
      pick = $urandom_range(0, 99);
      if (pick < 28) begin
         cmd.command = bpc_pkg::CMD_WRITE;
         cmd.start_x = near_coord(-3, span);
         cmd.start_y = near_coord(-3, span);
      end else if (pick < 50) begin
         cmd.command = bpc_pkg::CMD_FILL;
         cmd.start_x = near_coord(-4, span);
         cmd.start_y = near_coord(-4, span);
         // Width and height of -2 up to about half the span, so some rectangles are inverted.
         off = $urandom_range(0, span / 2 + 4);
         cmd.end_x = cmd.start_x + 16'(off - 2);
         off = $urandom_range(0, span / 2 + 4);
         cmd.end_y = cmd.start_y + 16'(off - 2);
      end else if (pick < 96) begin
         cmd.command  = bpc_pkg::CMD_TEST;
         cmd.box_only = ($urandom_range(0, 3) == 0);
         cmd.pos_a_x  = near_coord(-100, 100);
         cmd.pos_a_y  = near_coord(-100, 100);
         // B lands within one span of A; near the ends of the range the sum wraps.
         off = $urandom_range(0, 2 * span);
         cmd.pos_b_x = cmd.pos_a_x + 16'(off - span);
         off = $urandom_range(0, 2 * span);
         cmd.pos_b_y = cmd.pos_a_y + 16'(off - span);
      end else begin
         cmd.command = CMD_UNKNOWN;
      end
      return cmd;
   endfunction

   // Offer one command and return at the edge that accepts it. Valid stays high after the
   // handshake, so back-to-back items never drop it within a time step.
   task automatic send_command(input collision_cmd_type cmd);
      int gap;
      gap = send_burst ? 0 : pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      // The zero fill sits above pos_b_y, the tuser bits follow the package layout.
      req_tdata  <= {7'b0, cmd.pos_b_y, cmd.pos_b_x, cmd.pos_a_y, cmd.pos_a_x,
                     cmd.pixel_value, cmd.end_y, cmd.end_x, cmd.start_y, cmd.start_x};
      req_tuser  <= {cmd.box_only, cmd.which_mask, cmd.command};
      do @(posedge clock); while (!req_tready);
      collision_check.accept_command(cmd);
   endtask

   // Stop offering and wait until every expected result has come back.
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (collision_check.pending() != 0) @(negedge clock);
   endtask

   task automatic write_size(input bpc_pkg::csr_index_type idx, input int unsigned value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= bpc_pkg::CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_ready);
      collision_check.set_size(idx, bpc_pkg::CSR_DATA_W'(value));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // One phase: drain, program all four sizes, then a stream of random commands. Halfway
   // through, the sender pauses until the unit has answered everything.
   task automatic run_phase(input int unsigned wa, input int unsigned ha,
                            input int unsigned wb, input int unsigned hb,
                            input int count, input int density);
      int span;
      wait_drained();
      write_size(bpc_pkg::CSR_WIDTH_A, wa);
      write_size(bpc_pkg::CSR_HEIGHT_A, ha);
      write_size(bpc_pkg::CSR_WIDTH_B, wb);
      write_size(bpc_pkg::CSR_HEIGHT_B, hb);
      span = collision_check.clip_dim(wa);
      if (collision_check.clip_dim(ha) > span) span = collision_check.clip_dim(ha);
      if (collision_check.clip_dim(wb) > span) span = collision_check.clip_dim(wb);
      if (collision_check.clip_dim(hb) > span) span = collision_check.clip_dim(hb);
      span += 4;
      for (int n = 0; n < count; n++) begin
         if (n % 60 == 0) send_burst = ($urandom_range(0, 3) == 0);
         if (n == count / 2) wait_drained();
         send_command(random_command(span, density));
      end
   endtask

   // Receiver: sample at the rising edge, decide ready at the falling edge. Ready drops for
   // a random stall after each item, except in bursts, and once for a long hold-off that lets
   // the unit fill up and stall its input while the sender keeps offering.
   initial begin : result_side
      int stall;
      int results_seen;
      bit rsp_burst;
      stall = 0;
      results_seen = 0;
      rsp_burst = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         rsp_tready <= (stall == 0);
         if (stall > 0) stall--;
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            collision_check.check_verdict(rsp_tdata);
            results_seen++;
            if (results_seen % 64 == 0) rsp_burst = ($urandom_range(0, 2) == 0);
            if (results_seen == HOLD_AT) stall = HOLD_CYCLES;
            else stall = rsp_burst ? 0 : pick_gap();
         end
      end
   end

   // Ends the run if no channel has moved an item for too long.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: timeout, nothing accepted for %0d cycles", idle_cycles);
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin : stimulus
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part at the reset sizes of 64. The mask memories power up undefined, so the
      // first two fills cover both masks completely from the extreme corners of the range;
      // every later test then reads only written pixels, whatever the sizes become.
      send_burst = 1'b0;
      send_command(rect_command(1'b0, -32768, -32768, 32767, 32767, 1'b0));
      send_command(rect_command(1'b1, -32768, -32768, 32767, 32767, 1'b0));
      // Both masks clear at the same place: boxes overlap, the scan finds nothing.
      send_command(test_command(0, 0, 0, 0, 1'b0));
      send_command(pixel_command(1'b0, 5, 7, 1'b1));
      send_command(pixel_command(1'b1, 5, 7, 1'b1));
      send_command(test_command(-100, 20, -100, 20, 1'b0));
      // One column apart is rejected, edges that only touch are not.
      send_command(test_command(0, 0, 65, 0, 1'b1));
      send_command(test_command(0, 0, 64, 0, 1'b1));
      send_command(test_command(0, 0, 0, 64, 1'b0));
      // Writes outside the mask are ignored.
      send_command(pixel_command(1'b0, -1, 0, 1'b1));
      send_command(pixel_command(1'b0, 64, 63, 1'b1));
      send_command(pixel_command(1'b1, 32767, -32768, 1'b1));
      // Opposite corners meet in a one-pixel overlap.
      send_command(pixel_command(1'b0, 63, 63, 1'b1));
      send_command(pixel_command(1'b1, 0, 0, 1'b1));
      send_command(test_command(0, 0, 63, 63, 1'b0));
      // Positions at the ends of the coordinate range.
      send_command(test_command(-32768, -32768, 32767, 32767, 1'b0));
      send_command(test_command(32767, 32767, 32757, 32757, 1'b0));
      // Inverted and empty rectangles write nothing; a partly clipped one writes its inside.
      send_command(rect_command(1'b0, 10, 10, 5, 5, 1'b1));
      send_command(rect_command(1'b1, 20, 20, 20, 30, 1'b1));
      send_command(rect_command(1'b0, -5, 60, 3, 100, 1'b1));
      send_command(test_command(0, 0, -2, -60, 1'b0));
      send_command(test_command(0, 0, 0, 0, 1'b1));
      begin : unknown_op
         collision_cmd_type cmd;
         cmd = noise_command();
         cmd.command = CMD_UNKNOWN;
         send_command(cmd);
      end

      // Random phases over several size settings: full size (with the long receiver hold-off),
      // single pixel, empty masks, mixed empty and full, values above 64 that saturate, and
      // a few random sizes.
      run_phase(64, 64, 64, 64, 320, 30);
      run_phase(1, 1, 1, 1, 120, 50);
      run_phase(0, 0, 0, 0, 80, 50);
      run_phase(127, 127, 100, 65, 180, 20);
      run_phase(0, 64, 64, 1, 100, 40);
      repeat (4)
         run_phase($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(1, 64),
                   $urandom_range(1, 64), 140, $urandom_range(5, 60));

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (collision_check.mismatches == 0 && collision_check.pending() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
